### hdl/iee_pkg.sv
// Package for the infix expression evaluator: fixed-point limits, character
// codes, pending-operator codes and the sequencer state type.
// Depends on nothing; used by infix_expression_evaluator.
package iee_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int VALUE_WIDTH = 64;

  localparam logic [63:0] VMAX    = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
  localparam logic [63:0] VMIN    = ~VMAX;
  localparam logic [63:0] VLIMNEG = VMAX + 64'd1;
  localparam logic [63:0] FIX_LIM = VMAX >> FRAC_BITS;
  localparam logic [35:0] NUM_MAX = 36'h0_FFFF_FFFF;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [5:0] MUL_LAST = 6'd31;
  localparam logic [5:0] DIV_LAST = 6'd63;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PREP,
    S_MUL,
    S_DIV,
    S_SIGN,
    S_FOLD,
    S_EOL,
    S_OUT
  } state_t;

endpackage

### hdl/infix_expression_evaluator.sv
// Infix expression evaluator top level: character decoder, sequencer and one
// shared shift-add / shift-subtract unit for multiply and divide.
// Depends on iee_pkg.
//
// Usage: each input word carries one ASCII character (char_code) and an
// end_of_line flag. Digits build a decimal number; a space after a digit ends
// it; + - * / set operators with the usual precedence, left to right. The
// word flagged end_of_line closes the expression, and one output word then
// carries value (signed, FRAC_BITS fraction bits) and error (saturation or
// division by zero somewhere in the line).
// Input words are taken one at a time; in_stall is high while a word is at
// work. A digit, a * or /, or an ignored character passes decode and the
// end-of-line check; a + or - also passes a fold step. A space that ends a
// number adds a preparation step, then with a pending multiply one multiplier
// bit per cycle over 32 bits and a sign step, and with a pending nonzero
// divide one quotient bit per cycle over 64 bits and a sign step. End of line
// adds the number completion if any, a fold step and an output step.
// The output register lets the next line start while a result waits; if the
// receiver stalls a second result, the block holds in its output state.
// Reset (rst, synchronous) clears the expression state and the output valid.
module infix_expression_evaluator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        end_of_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] value,
  output logic        error
);

  iee_pkg::state_t state, state_next;

  logic [7:0]  char_hold;
  logic        eol_hold;
  logic [63:0] running_sum;
  logic [63:0] product_term;
  logic [31:0] number_accum;
  logic        add_sign;
  iee_pkg::op_t mul_pending;
  logic        prev_was_digit;
  logic        error_seen;
  logic        final_phase;
  logic [63:0] mag;
  logic        neg;
  logic [65:0] acc;
  logic        ovf;
  logic [31:0] rem;
  logic [5:0]  cnt;

  logic        in_take;
  logic        out_load;
  logic        is_digit;
  logic [35:0] acc10;
  logic        need_complete;
  logic [63:0] mul_limit;
  logic [65:0] acc_step;
  logic [32:0] trial;
  logic [32:0] trial_diff;
  logic        trial_ok;
  logic [63:0] addend;
  logic        carry_in;
  logic        fold_min;
  logic [64:0] fold_sum;
  logic        fold_hi;
  logic        fold_lo;
  logic [63:0] sign_mag;

  assign in_take  = in_valid && !in_stall;
  assign is_digit = (char_hold >= iee_pkg::CH_ZERO) && (char_hold <= iee_pkg::CH_NINE);
  assign acc10    = ({4'b0, number_accum} << 3) + ({4'b0, number_accum} << 1)
                  + {32'b0, char_hold[3:0]};
  assign need_complete = is_digit || (number_accum != 32'd0) ||
                         (mul_pending == iee_pkg::OP_MUL) || (mul_pending == iee_pkg::OP_DIV);

  assign mul_limit  = neg ? iee_pkg::VLIMNEG : iee_pkg::VMAX;
  assign acc_step   = {acc[64:0], 1'b0} +
                      (number_accum[~cnt[4:0]] ? {2'b0, mag} : 66'd0);
  assign trial      = {rem, mag[63]};
  assign trial_diff = trial - {1'b0, number_accum};
  assign trial_ok   = trial >= {1'b0, number_accum};
  assign sign_mag   = (mul_pending == iee_pkg::OP_MUL) ? acc[63:0] : mag;

  assign fold_min = product_term == iee_pkg::VMIN;
  always_comb begin
    if (!add_sign) begin
      addend   = product_term;
      carry_in = 1'b0;
    end else if (fold_min) begin
      addend   = iee_pkg::VMAX;
      carry_in = 1'b0;
    end else begin
      addend   = ~product_term;
      carry_in = 1'b1;
    end
  end
  assign fold_sum = {running_sum[63], running_sum} + {addend[63], addend}
                  + {64'b0, carry_in};
  assign fold_hi  = $signed(fold_sum) > $signed({1'b0, iee_pkg::VMAX});
  assign fold_lo  = $signed(fold_sum) < $signed({1'b1, iee_pkg::VMIN});

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    unique case (state)
      iee_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_next = iee_pkg::S_DECODE;
      end
      iee_pkg::S_DECODE: begin
        if (char_hold == iee_pkg::CH_SPACE && prev_was_digit) begin
          state_next = iee_pkg::S_PREP;
        end else if (char_hold == iee_pkg::CH_PLUS || char_hold == iee_pkg::CH_MINUS) begin
          state_next = iee_pkg::S_FOLD;
        end else begin
          state_next = iee_pkg::S_EOL;
        end
      end
      iee_pkg::S_PREP: begin
        if (mul_pending == iee_pkg::OP_MUL) begin
          state_next = iee_pkg::S_MUL;
        end else if (mul_pending == iee_pkg::OP_DIV && number_accum != 32'd0) begin
          state_next = iee_pkg::S_DIV;
        end else begin
          state_next = final_phase ? iee_pkg::S_FOLD : iee_pkg::S_EOL;
        end
      end
      iee_pkg::S_MUL: begin
        if (cnt == iee_pkg::MUL_LAST) state_next = iee_pkg::S_SIGN;
      end
      iee_pkg::S_DIV: begin
        if (cnt == iee_pkg::DIV_LAST) state_next = iee_pkg::S_SIGN;
      end
      iee_pkg::S_SIGN: begin
        state_next = final_phase ? iee_pkg::S_FOLD : iee_pkg::S_EOL;
      end
      iee_pkg::S_FOLD: begin
        state_next = final_phase ? iee_pkg::S_OUT : iee_pkg::S_EOL;
      end
      iee_pkg::S_EOL: begin
        if (!eol_hold) begin
          state_next = iee_pkg::S_IDLE;
        end else begin
          state_next = need_complete ? iee_pkg::S_PREP : iee_pkg::S_FOLD;
        end
      end
      iee_pkg::S_OUT: begin
        out_load = !out_valid || !out_stall;
        if (out_load) state_next = iee_pkg::S_IDLE;
      end
      default: state_next = iee_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iee_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      char_hold <= char_code;
      eol_hold  <= end_of_line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= '0;
      product_term   <= '0;
      number_accum   <= '0;
      add_sign       <= 1'b0;
      mul_pending    <= iee_pkg::OP_NONE;
      prev_was_digit <= 1'b0;
      error_seen     <= 1'b0;
      final_phase    <= 1'b0;
    end else begin
      unique case (state)
        iee_pkg::S_DECODE: begin
          prev_was_digit <= is_digit;
          if (is_digit) begin
            if (acc10 > iee_pkg::NUM_MAX) begin
              number_accum <= '1;
              error_seen   <= 1'b1;
            end else begin
              number_accum <= acc10[31:0];
            end
          end else if (char_hold == iee_pkg::CH_STAR) begin
            mul_pending <= iee_pkg::OP_MUL;
          end else if (char_hold == iee_pkg::CH_SLASH) begin
            mul_pending <= iee_pkg::OP_DIV;
          end
        end
        iee_pkg::S_PREP: begin
          neg <= product_term[63];
          mag <= product_term[63] ? (64'd0 - product_term) : product_term;
          acc <= '0;
          ovf <= 1'b0;
          rem <= '0;
          cnt <= '0;
          if (mul_pending == iee_pkg::OP_DIV && number_accum == 32'd0) begin
            product_term <= product_term[63] ? iee_pkg::VMIN : iee_pkg::VMAX;
            error_seen   <= 1'b1;
            number_accum <= '0;
            mul_pending  <= iee_pkg::OP_NONE;
          end else if (mul_pending != iee_pkg::OP_MUL && mul_pending != iee_pkg::OP_DIV) begin
            if ({32'b0, number_accum} > iee_pkg::FIX_LIM) begin
              product_term <= iee_pkg::VMAX;
              error_seen   <= 1'b1;
            end else begin
              product_term <= {32'b0, number_accum} << iee_pkg::FRAC_BITS;
            end
            number_accum <= '0;
            mul_pending  <= iee_pkg::OP_NONE;
          end
        end
        iee_pkg::S_MUL: begin
          acc <= acc_step;
          if (acc_step > {2'b0, mul_limit}) ovf <= 1'b1;
          cnt <= cnt + 6'd1;
        end
        iee_pkg::S_DIV: begin
          rem <= trial_ok ? trial_diff[31:0] : trial[31:0];
          mag <= {mag[62:0], trial_ok};
          cnt <= cnt + 6'd1;
        end
        iee_pkg::S_SIGN: begin
          if (ovf && mul_pending == iee_pkg::OP_MUL) begin
            product_term <= neg ? iee_pkg::VMIN : iee_pkg::VMAX;
            error_seen   <= 1'b1;
          end else begin
            product_term <= neg ? (64'd0 - sign_mag) : sign_mag;
          end
          number_accum <= '0;
          mul_pending  <= iee_pkg::OP_NONE;
        end
        iee_pkg::S_FOLD: begin
          if (fold_hi) begin
            running_sum <= iee_pkg::VMAX;
          end else if (fold_lo) begin
            running_sum <= iee_pkg::VMIN;
          end else begin
            running_sum <= fold_sum[63:0];
          end
          if (fold_hi || fold_lo || (add_sign && fold_min)) error_seen <= 1'b1;
          product_term <= '0;
          mul_pending  <= iee_pkg::OP_NONE;
          if (!final_phase) add_sign <= (char_hold == iee_pkg::CH_MINUS);
        end
        iee_pkg::S_EOL: begin
          if (eol_hold) final_phase <= 1'b1;
        end
        iee_pkg::S_OUT: begin
          if (out_load) begin
            running_sum    <= '0;
            product_term   <= '0;
            number_accum   <= '0;
            add_sign       <= 1'b0;
            mul_pending    <= iee_pkg::OP_NONE;
            prev_was_digit <= 1'b0;
            error_seen     <= 1'b0;
            final_phase    <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      value <= running_sum;
      error <= error_seen;
    end
  end

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == iee_pkg::S_DIV |-> rem < number_accum)
    else $error("Division remainder is not below the divisor.");

  a_div_full_length: assert property (@(posedge clk) disable iff (rst)
    state == iee_pkg::S_DIV && cnt != iee_pkg::DIV_LAST |=> state == iee_pkg::S_DIV)
    else $error("Division left before all quotient bits were formed.");

  a_sign_has_op: assert property (@(posedge clk) disable iff (rst)
    state == iee_pkg::S_SIGN |->
      (mul_pending == iee_pkg::OP_MUL || mul_pending == iee_pkg::OP_DIV))
    else $error("Result sign stage reached without a pending multiply or divide.");

  a_out_clears_line: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && running_sum == 64'd0 && product_term == 64'd0 &&
                 !error_seen && !final_phase)
    else $error("Expression state not cleared after the result word was loaded.");

  a_idle_no_final: assert property (@(posedge clk) disable iff (rst)
    state == iee_pkg::S_IDLE |-> !final_phase)
    else $error("End-of-line phase still set while waiting for a word.");

endmodule
